// ===== src/bbd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbd_pkg
// Shared widths, register indexes and parameter defaults of the Bayer
// bilinear demosaic block.
// ----------------------------------------------------------------------------
package bbd_pkg;

	// Width of the pixel fields on the ports.
	localparam int PIX_PORT_W = 16;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam logic [CFG_DATA_W-1:0] FRAME_DIM_RESET = 13'd4096;
	localparam logic [CFG_DATA_W-1:0] FRAME_DIM_MIN   = 13'd3;
	localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_MAX = 13'd4096;

	// Row counter width (at most 4096 rows) and width of length arithmetic
	// (large enough for MAX_WIDTH + 1 at its largest).
	localparam int ROW_W = 12;
	localparam int LEN_W = 15;

	// Parameter defaults.
	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int PIXEL_BITS_DEF = 16;

endpackage
`default_nettype wire

// ===== src/bbd_pix_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbd_pix_if
// Raw pixel channel: a pixel or a flush command per word.
// ----------------------------------------------------------------------------
interface bbd_pix_if;
	import bbd_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  cmd;
	logic [PIX_PORT_W-1:0] raw_pixel;

	modport source (output valid, output cmd, output raw_pixel, input ready);
	modport sink   (input valid, input cmd, input raw_pixel, output ready);

endinterface
`default_nettype wire

// ===== src/bbd_rgb_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbd_rgb_if
// RGB result channel with an end-of-frame mark.
// ----------------------------------------------------------------------------
interface bbd_rgb_if;
	import bbd_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [PIX_PORT_W-1:0] red;
	logic [PIX_PORT_W-1:0] green;
	logic [PIX_PORT_W-1:0] blue;
	logic                  frame_end;

	modport source (output valid, output red, output green, output blue,
		output frame_end, input ready);
	modport sink   (input valid, input red, input green, input blue,
		input frame_end, output ready);

endinterface
`default_nettype wire

// ===== src/bbd_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbd_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bbd_cfg_if;
	import bbd_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);

endinterface
`default_nettype wire

// ===== src/bbd_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bbd_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. A read of the address being written returns the
// old contents.
// ----------------------------------------------------------------------------
module bbd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== src/bayer_bilinear_demosaic.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic
// Streaming bilinear demosaic of an RGGB Bayer raster with two line stores.
// ----------------------------------------------------------------------------
// The block takes one word per clock, a raw pixel in raster order or a flush
// command, and gives one RGB word per clock, both while rgb.ready holds. Each
// pixel's color comes out width+1 positions after the pixel itself went in;
// after a frame's last pixel, width+1 flush words draw out the remaining
// results, the last one marked with frame_end. Flushes with nothing pending
// are taken and dropped. A word is in a two-stage pipe: the first stage reads
// the two line store RAMs (registered read), the second forms the colors from
// the 3x3 window into the output register; the sustained rate is one word per
// clock while rgb.ready holds. The line stores hold no meaningful data after
// reset and need no clearing pass. The user must write frame width and height
// only between frames; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module bayer_bilinear_demosaic #(
	parameter int MAX_WIDTH  = bbd_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = bbd_pkg::PIXEL_BITS_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	bbd_pix_if.sink   pix,
	bbd_rgb_if.source rgb,
	bbd_cfg_if.sink   cfg
);
	import bbd_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int P     = PIXEL_BITS;

	localparam logic [1:0] CLR_RED      = 2'd0;
	localparam logic [1:0] CLR_GREEN_R  = 2'd1;
	localparam logic [1:0] CLR_GREEN_B  = 2'd2;
	localparam logic [1:0] CLR_BLUE     = 2'd3;

	// ---------------- configuration ----------------
	logic [CFG_DATA_W-1:0] width_q;
	logic [CFG_DATA_W-1:0] height_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= FRAME_DIM_RESET;
			height_q <= FRAME_DIM_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_FRAME_WIDTH:  width_q  <= cfg.data;
				REG_FRAME_HEIGHT: height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	logic [LEN_W-1:0]      eff_w;
	logic [CFG_DATA_W-1:0] eff_h;

	always_comb begin
		if (width_q < FRAME_DIM_MIN) begin
			eff_w = LEN_W'(FRAME_DIM_MIN);
		end else if (LEN_W'(width_q) > LEN_W'(MAX_WIDTH)) begin
			eff_w = LEN_W'(MAX_WIDTH);
		end else begin
			eff_w = LEN_W'(width_q);
		end
		if (height_q < FRAME_DIM_MIN) begin
			eff_h = FRAME_DIM_MIN;
		end else if (height_q > FRAME_HEIGHT_MAX) begin
			eff_h = FRAME_HEIGHT_MAX;
		end else begin
			eff_h = height_q;
		end
	end

	// ---------------- stage 1: position, flush count, RAM reads ----------------
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [LEN_W-1:0] flush_cnt_q;

	logic             valid_s1;
	logic             flush_s1;
	logic             res_s1;
	logic             border_s1;
	logic [1:0]       color_s1;
	logic             end_s1;
	logic             up2_ok_s1;
	logic             up1_ok_s1;
	logic             par_s1;
	logic             fbank_s1;
	logic [P-1:0]     raw_s1;

	logic out_valid_s2;
	logic adv;
	logic acc;
	logic load;

	assign adv       = !out_valid_s2 || rgb.ready;
	assign pix.ready = !valid_s1 || adv;
	assign acc       = pix.valid && pix.ready;
	assign load      = acc && (!pix.cmd || (flush_cnt_q != '0));

	logic [LEN_W-1:0]      c_ext;
	logic [CFG_DATA_W-1:0] r_ext;
	logic [LEN_W-1:0]      w_m1;
	logic [LEN_W-1:0]      w_p1;
	logic [LEN_W-1:0]      k_val;
	logic [LEN_W-1:0]      k_m1;
	logic                  k_zero;
	logic                  col_last;
	logic                  row_last;
	logic                  interior;
	logic [COL_W-1:0]      faddr;
	logic [COL_W-1:0]      raddr;
	logic [P-1:0]          raw_in;

	always_comb begin
		c_ext    = LEN_W'(col_q);
		r_ext    = CFG_DATA_W'(row_q);
		w_m1     = eff_w - LEN_W'(1);
		w_p1     = eff_w + LEN_W'(1);
		k_val    = (flush_cnt_q > w_p1) ? '0 : (w_p1 - flush_cnt_q);
		k_zero   = (k_val == '0);
		k_m1     = k_val - LEN_W'(1);
		col_last = (c_ext + LEN_W'(1)) >= eff_w;
		row_last = (r_ext + CFG_DATA_W'(1)) >= eff_h;
		interior = (r_ext >= CFG_DATA_W'(2)) && ((r_ext + CFG_DATA_W'(1)) <= eff_h)
			&& (c_ext >= LEN_W'(2)) && ((c_ext + LEN_W'(1)) <= eff_w);
		faddr    = k_zero ? COL_W'(w_m1) : COL_W'(k_m1);
		raddr    = pix.cmd ? faddr : col_q;
		raw_in   = pix.raw_pixel[P-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			flush_cnt_q <= '0;
			valid_s1    <= 1'b0;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (load && pix.cmd) begin
				flush_cnt_q <= flush_cnt_q - LEN_W'(1);
			end else if (load) begin
				if (col_last) begin
					col_q <= '0;
					if (row_last) begin
						row_q       <= '0;
						flush_cnt_q <= w_p1;
					end else begin
						row_q       <= row_q + ROW_W'(1);
						flush_cnt_q <= '0;
					end
				end else begin
					col_q       <= col_q + COL_W'(1);
					flush_cnt_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			flush_s1  <= pix.cmd;
			raw_s1    <= raw_in;
			par_s1    <= row_q[0];
			up2_ok_s1 <= (row_q >= ROW_W'(2));
			up1_ok_s1 <= (row_q >= ROW_W'(1));
			fbank_s1  <= k_zero ? eff_h[0] : !eff_h[0];
			end_s1    <= pix.cmd && (flush_cnt_q == LEN_W'(1));
			if (pix.cmd) begin
				res_s1    <= 1'b1;
				border_s1 <= 1'b1;
				color_s1  <= k_zero ? {eff_h[0], w_m1[0]} : {!eff_h[0], k_m1[0]};
			end else if (col_q == '0) begin
				// First column: emit the last pixel of the row two rows up.
				res_s1    <= (row_q >= ROW_W'(2));
				border_s1 <= 1'b1;
				color_s1  <= {row_q[0], w_m1[0]};
			end else begin
				res_s1    <= (row_q >= ROW_W'(1));
				border_s1 <= !interior;
				color_s1  <= {!row_q[0], !col_q[0]};
			end
		end
	end

	// Line stores: row r lives in bank r&1.
	logic [P-1:0] rd0;
	logic [P-1:0] rd1;
	logic         we0;
	logic         we1;

	assign we0 = load && !pix.cmd && !row_q[0];
	assign we1 = load && !pix.cmd && row_q[0];

	bbd_ram #(.WIDTH(P), .DEPTH(MAX_WIDTH)) u_bank0 (
		.clk   (clk),
		.we    (we0),
		.waddr (col_q),
		.wdata (raw_in),
		.re    (load),
		.raddr (raddr),
		.rdata (rd0)
	);

	bbd_ram #(.WIDTH(P), .DEPTH(MAX_WIDTH)) u_bank1 (
		.clk   (clk),
		.we    (we1),
		.waddr (col_q),
		.wdata (raw_in),
		.re    (load),
		.raddr (raddr),
		.rdata (rd1)
	);

	// ---------------- stage 2: window and color formation ----------------
	logic [P-1:0] win0_q [3];
	logic [P-1:0] win1_q [3];

	logic [P-1:0]   up2;
	logic [P-1:0]   up1;
	logic [P-1:0]   bval;
	logic [P+1:0]   sum_cross;
	logic [P:0]     sum_horiz;
	logic [P:0]     sum_vert;
	logic [P:0]     sum_top;
	logic [P:0]     sum_bot;
	logic [P:0]     sum_diag;
	logic [P-1:0]   v_cross;
	logic [P-1:0]   v_horiz;
	logic [P-1:0]   v_vert;
	logic [P-1:0]   v_diag;
	logic [P-1:0]   r_nx;
	logic [P-1:0]   g_nx;
	logic [P-1:0]   b_nx;

	always_comb begin
		up2  = up2_ok_s1 ? (par_s1 ? rd1 : rd0) : '0;
		up1  = up1_ok_s1 ? (par_s1 ? rd0 : rd1) : '0;
		bval = flush_s1 ? (fbank_s1 ? rd1 : rd0) : win1_q[1];

		// Window: column 0 is win0_q, column 1 is win1_q, column 2 is
		// {up2, up1, raw}; row 0 is the top.
		sum_cross = (P+2)'(win1_q[0]) + (P+2)'(win1_q[2])
			+ (P+2)'(win0_q[1]) + (P+2)'(up1);
		sum_horiz = (P+1)'(win0_q[1]) + (P+1)'(up1);
		sum_vert  = (P+1)'(win1_q[0]) + (P+1)'(win1_q[2]) + (P+1)'(1);
		sum_top   = (P+1)'(win0_q[0]) + (P+1)'(up2);
		sum_bot   = (P+1)'(win0_q[2]) + (P+1)'(raw_s1);
		sum_diag  = (P+1)'(sum_top[P:1]) + (P+1)'(sum_bot[P:1]) + (P+1)'(1);
		v_cross   = sum_cross[P+1:2];
		v_horiz   = sum_horiz[P:1];
		v_vert    = sum_vert[P:1];
		v_diag    = sum_diag[P:1];

		r_nx = '0;
		g_nx = '0;
		b_nx = '0;
		if (border_s1) begin
			case (color_s1)
				CLR_RED:  r_nx = bval;
				CLR_BLUE: b_nx = bval;
				default:  g_nx = bval;
			endcase
		end else begin
			case (color_s1)
				CLR_RED: begin
					r_nx = win1_q[1];
					g_nx = v_cross;
					b_nx = v_diag;
				end
				CLR_GREEN_R: begin
					r_nx = v_horiz;
					g_nx = win1_q[1];
					b_nx = v_vert;
				end
				CLR_GREEN_B: begin
					r_nx = v_vert;
					g_nx = win1_q[1];
					b_nx = v_horiz;
				end
				default: begin
					r_nx = v_diag;
					g_nx = v_cross;
					b_nx = win1_q[1];
				end
			endcase
		end
	end

	logic [PIX_PORT_W-1:0] red_s2;
	logic [PIX_PORT_W-1:0] green_s2;
	logic [PIX_PORT_W-1:0] blue_s2;
	logic                  end_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				win0_q[i] <= '0;
				win1_q[i] <= '0;
			end
		end else if (adv) begin
			out_valid_s2 <= valid_s1 && res_s1;
			if (valid_s1 && !flush_s1) begin
				for (int i = 0; i < 3; i++) begin
					win0_q[i] <= win1_q[i];
				end
				win1_q[0] <= up2;
				win1_q[1] <= up1;
				win1_q[2] <= raw_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			red_s2   <= PIX_PORT_W'(r_nx);
			green_s2 <= PIX_PORT_W'(g_nx);
			blue_s2  <= PIX_PORT_W'(b_nx);
			end_s2   <= end_s1;
		end
	end

	assign rgb.valid     = out_valid_s2;
	assign rgb.red       = red_s2;
	assign rgb.green     = green_s2;
	assign rgb.blue      = blue_s2;
	assign rgb.frame_end = end_s2;

	// ---------------- assertions ----------------
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pix.ready |-> (valid_s1 && out_valid_s2))
		else $error("input stalled while the pipe has room");

	a_idle_flush_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && pix.cmd && (flush_cnt_q == '0) && !valid_s1) |=> !valid_s1)
		else $error("flush with nothing pending entered the pipe");

	a_flush_counts_down: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && pix.cmd && (flush_cnt_q != '0))
		|=> (flush_cnt_q == $past(flush_cnt_q) - LEN_W'(1)))
		else $error("pending count did not step down on a flush");

	a_pixel_clears_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !pix.cmd && !(col_last && row_last)) |=> (flush_cnt_q == '0))
		else $error("pending results survived a mid-frame pixel");

endmodule
`default_nettype wire

// ===== bench/tb_bayer_bilinear_demosaic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bayer_bilinear_demosaic
// Self-checking bench for the RGGB bilinear demosaic. A short directed run
// covers the smallest frame, full-scale and zero pixels, stray flushes and a
// flush run cut short by new pixels. Random frames of random sizes follow,
// plus one widest and one tallest frame. Every RGB word is checked against
// given words or a behavioral model of the line stores and the 3x3 window.
// ----------------------------------------------------------------------------
module tb_bayer_bilinear_demosaic;
	import bbd_pkg::*;

	localparam int LINE_LEN      = MAX_WIDTH_DEF;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT   = 200000;
	localparam int MAX_SHOWN     = 10;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	typedef struct packed {
		logic [PIX_PORT_W-1:0] red;
		logic [PIX_PORT_W-1:0] green;
		logic [PIX_PORT_W-1:0] blue;
		logic                  frame_end;
	} rgb_word_t;

	localparam rgb_word_t RED_FULL   = {16'hFFFF, 16'h0000, 16'h0000, 1'b0};
	localparam rgb_word_t GREEN_FULL = {16'h0000, 16'hFFFF, 16'h0000, 1'b0};
	localparam rgb_word_t WHITE_FULL = {16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0};
	localparam rgb_word_t BLACK      = {16'h0000, 16'h0000, 16'h0000, 1'b0};
	localparam rgb_word_t BLACK_LAST = {16'h0000, 16'h0000, 16'h0000, 1'b1};

	typedef enum logic [1:0] {ROW_SIZE, ROW_PIXEL, ROW_FLUSH} row_kind_e;
	typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_GIVEN} row_check_e;

	typedef struct {
		row_kind_e             kind;
		logic [15:0]           value;
		logic [CFG_DATA_W-1:0] height;
		row_check_e            check;
		rgb_word_t             given;
	} stim_row_t;

	logic clk;
	logic arst_n;

	bbd_pix_if pix_ch ();
	bbd_rgb_if rgb_ch ();
	bbd_cfg_if cfg_ch ();

	bayer_bilinear_demosaic DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_ch),
		.rgb    (rgb_ch),
		.cfg    (cfg_ch)
	);

	// Model state: row r of the frame lives in bank r % 2.
	logic [PIX_PORT_W-1:0]      line_mem [0:2*LINE_LEN-1];
	logic [2:0][PIX_PORT_W-1:0] win_prev;
	logic [2:0][PIX_PORT_W-1:0] win_last;
	int unsigned                row_pos;
	int unsigned                col_pos;
	int unsigned                pending_flush;
	logic [CFG_DATA_W-1:0]      width_reg;
	logic [CFG_DATA_W-1:0]      height_reg;

	rgb_word_t expected_q [$];
	stim_row_t stim_rows [$];
	int errors     = 0;
	int stim_count = 0;
	int gap_pct    = 0;
	int stall_pct  = 0;

	function automatic int unsigned clamp_dim(logic [CFG_DATA_W-1:0] v, int unsigned top);
		if (v < FRAME_DIM_MIN)
			return FRAME_DIM_MIN;
		if (v > top)
			return top;
		return v;
	endfunction

	function automatic rgb_word_t border_color(int unsigned r, int unsigned c,
			logic [PIX_PORT_W-1:0] v);
		rgb_word_t o;
		o = '0;
		if (r[0] == 1'b0 && c[0] == 1'b0)
			o.red = v;
		else if (r[0] == 1'b1 && c[0] == 1'b1)
			o.blue = v;
		else
			o.green = v;
		return o;
	endfunction

	function automatic rgb_word_t interior_color(int unsigned r, int unsigned c,
			logic [2:0][2:0][PIX_PORT_W-1:0] a);
		int unsigned mean4, horiz, vert, diag_up, diag_dn, diag;
		rgb_word_t o;
		// Sums are 32 bits wide, so nothing saturates before the shift.
		mean4 = a[0][1];
		mean4 = (mean4 + a[2][1] + a[1][0] + a[1][2]) >> 2;
		horiz = a[1][0];
		horiz = (horiz + a[1][2]) >> 1;
		vert = a[0][1];
		vert = (vert + a[2][1] + 1) >> 1;
		diag_up = a[0][0];
		diag_up = (diag_up + a[0][2]) >> 1;
		diag_dn = a[2][0];
		diag_dn = (diag_dn + a[2][2]) >> 1;
		diag = (diag_up + diag_dn + 1) >> 1;
		case ({r[0], c[0]})
			2'b00: o = {a[1][1], mean4[15:0], diag[15:0], 1'b0};
			2'b01: o = {horiz[15:0], a[1][1], vert[15:0], 1'b0};
			2'b10: o = {vert[15:0], a[1][1], horiz[15:0], 1'b0};
			default: o = {diag[15:0], mean4[15:0], a[1][1], 1'b0};
		endcase
		return o;
	endfunction

	// Advances the model by one word; returns 1 when the word yields an RGB word.
	function automatic bit predict_word(logic cmd, logic [PIX_PORT_W-1:0] raw,
			output rgb_word_t res);
		int unsigned w, h, r, c, k;
		logic [2:0][2:0][PIX_PORT_W-1:0] a;
		bit hit;
		w = clamp_dim(width_reg, LINE_LEN);
		h = clamp_dim(height_reg, FRAME_HEIGHT_MAX);
		res = '0;
		hit = 1'b0;
		if (cmd == CMD_FLUSH) begin
			if (pending_flush == 0)
				return 1'b0;
			k = (pending_flush > w + 1) ? 0 : w + 1 - pending_flush;
			// The first flush still owes the last pixel of the next-to-last row.
			if (k == 0)
				res = border_color(h - 2, w - 1, line_mem[(h % 2) * LINE_LEN + w - 1]);
			else
				res = border_color(h - 1, k - 1,
					line_mem[((h - 1) % 2) * LINE_LEN + k - 1]);
			res.frame_end = (pending_flush == 1);
			pending_flush--;
			return 1'b1;
		end
		pending_flush = 0;
		r = row_pos;
		c = col_pos;
		for (int i = 0; i < 3; i++) begin
			a[i][0] = win_prev[i];
			a[i][1] = win_last[i];
		end
		a[0][2] = (r >= 2) ? line_mem[(r % 2) * LINE_LEN + c] : '0;
		a[1][2] = (r >= 1) ? line_mem[((r + 1) % 2) * LINE_LEN + c] : '0;
		a[2][2] = raw;
		if (c == 0) begin
			if (r >= 2) begin
				res = border_color(r - 2, w - 1, a[1][1]);
				hit = 1'b1;
			end
		end else if (r >= 1) begin
			if (r >= 2 && r + 1 <= h && c >= 2 && c + 1 <= w)
				res = interior_color(r - 1, c - 1, a);
			else
				res = border_color(r - 1, c - 1, a[1][1]);
			hit = 1'b1;
		end
		line_mem[(r % 2) * LINE_LEN + c] = raw;
		win_prev = win_last;
		for (int i = 0; i < 3; i++)
			win_last[i] = a[i][2];
		if (c + 1 >= w) begin
			col_pos = 0;
			if (r + 1 >= h) begin
				row_pos = 0;
				pending_flush = w + 1;
			end else begin
				row_pos = r + 1;
			end
		end else begin
			col_pos = c + 1;
		end
		return hit;
	endfunction

	function automatic logic [PIX_PORT_W-1:0] pick_raw();
		logic [PIX_PORT_W-1:0] v;
		v = $urandom;
		case ($urandom_range(9, 0))
			0: v = 16'hFFFF;
			1: v = 16'h0000;
			2: v = $urandom_range(3, 0);
			3: v = 16'hFFFF - $urandom_range(3, 0);
			default: ;
		endcase
		return v;
	endfunction

	function automatic int pick_rate();
		case ($urandom_range(3, 0))
			0: return 0;
			1: return 3;
			2: return 15;
			default: return 40;
		endcase
	endfunction

	task automatic add_row(row_kind_e kind, logic [15:0] value,
			logic [CFG_DATA_W-1:0] height, row_check_e check, rgb_word_t given);
		stim_row_t row;
		row.kind = kind;
		row.value = value;
		row.height = height;
		row.check = check;
		row.given = given;
		stim_rows.push_back(row);
	endtask

	task automatic send_word(logic cmd, logic [PIX_PORT_W-1:0] raw, row_check_e check,
			rgb_word_t given);
		rgb_word_t pred;
		bit hit;
		if (gap_pct > 0 && $urandom_range(99, 0) < gap_pct) begin
			pix_ch.valid <= 1'b0;
			repeat ($urandom_range(17, 1)) @(posedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.cmd <= cmd;
		pix_ch.raw_pixel <= raw;
		do @(posedge clk); while (pix_ch.ready !== 1'b1);
		hit = predict_word(cmd, raw, pred);
		if (check == CHK_GIVEN)
			expected_q.push_back(given);
		else if (check == CHK_MODEL && hit)
			expected_q.push_back(pred);
		if (cmd == CMD_PIXEL || hit)
			stim_count++;
	endtask

	// Holds the sender until every pending word has come out, then lets the
	// pipe settle so that a dropped flush is also gone.
	task automatic wait_drained();
		pix_ch.valid <= 1'b0;
		for (int n = 0; n < DRAIN_LIMIT && expected_q.size() != 0; n++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_size(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
		wait_drained();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= REG_FRAME_WIDTH;
		cfg_ch.data <= w;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		width_reg = w;
		cfg_ch.index <= REG_FRAME_HEIGHT;
		cfg_ch.data <= h;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		height_reg = h;
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic pick_small_size();
		logic [CFG_DATA_W-1:0] w, h;
		// Values below the minimum are clamped by the block.
		case ($urandom_range(5, 0))
			0: w = $urandom_range(2, 0);
			1: w = FRAME_DIM_MIN;
			default: w = $urandom_range(12, 4);
		endcase
		case ($urandom_range(5, 0))
			0: h = $urandom_range(2, 0);
			1: h = FRAME_DIM_MIN;
			default: h = $urandom_range(8, 4);
		endcase
		set_size(w, h);
	endtask

	// One whole frame of random pixels with stray flushes mixed in, ended by a
	// full, partial or missing flush run, and optionally paused once to drain.
	task automatic run_frame(bit pause_once);
		int unsigned w, h, n, tail, pause_at;
		w = clamp_dim(width_reg, LINE_LEN);
		h = clamp_dim(height_reg, FRAME_HEIGHT_MAX);
		n = w * h;
		pause_at = $urandom_range(n - 1, 1);
		for (int unsigned i = 0; i < n; i++) begin
			// No flush before the first pixel: the size may have just changed.
			if (i != 0 && $urandom_range(99, 0) < 4)
				send_word(CMD_FLUSH, $urandom, CHK_MODEL, '0);
			if (pause_once && i == pause_at)
				wait_drained();
			send_word(CMD_PIXEL, pick_raw(), CHK_MODEL, '0);
		end
		case ($urandom_range(9, 0))
			0: tail = 0;
			1, 2: tail = $urandom_range(w, 1);
			default: tail = w + 1 + $urandom_range(1, 0) * $urandom_range(3, 1);
		endcase
		repeat (tail) send_word(CMD_FLUSH, $urandom, CHK_MODEL, '0);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Verification failed");
		$finish;
	end

	// Result side: random stall bursts, and the check of every accepted word.
	initial begin
		int stall_left;
		rgb_word_t got, want;
		stall_left = 0;
		rgb_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && rgb_ch.valid === 1'b1 && rgb_ch.ready === 1'b1) begin
				got = {rgb_ch.red, rgb_ch.green, rgb_ch.blue, rgb_ch.frame_end};
				if (expected_q.size() == 0) begin
					errors++;
					if (errors <= MAX_SHOWN)
						$display("%0t: unexpected RGB word r=%h g=%h b=%h end=%b",
							$time, got.red, got.green, got.blue, got.frame_end);
				end else begin
					want = expected_q.pop_front();
					if (got.red !== want.red || got.green !== want.green ||
							got.blue !== want.blue || got.frame_end !== want.frame_end) begin
						errors++;
						if (errors <= MAX_SHOWN)
							$display({"%0t: mismatch: expected r=%h g=%h b=%h end=%b, ",
								"got r=%h g=%h b=%h end=%b"}, $time,
								want.red, want.green, want.blue, want.frame_end,
								got.red, got.green, got.blue, got.frame_end);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				rgb_ch.ready <= 1'b0;
			end else if (stall_pct > 0 && $urandom_range(99, 0) < stall_pct) begin
				stall_left = $urandom_range(16, 0);
				rgb_ch.ready <= 1'b0;
			end else begin
				rgb_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int tail_mark;
		pix_ch.valid <= 1'b0;
		pix_ch.cmd <= CMD_PIXEL;
		pix_ch.raw_pixel <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_FRAME_WIDTH;
		cfg_ch.data <= '0;
		arst_n <= 1'b0;
		row_pos = 0;
		col_pos = 0;
		pending_flush = 0;
		win_prev = '0;
		win_last = '0;
		width_reg = FRAME_DIM_RESET;
		height_reg = FRAME_DIM_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Smallest frame in full scale, then an all-zero frame that cuts off
		// the first frame's flush run.
		add_row(ROW_FLUSH, 16'h0000, '0, CHK_NONE, '0);
		add_row(ROW_SIZE, FRAME_DIM_MIN, FRAME_DIM_MIN, CHK_NONE, '0);
		repeat (4) add_row(ROW_PIXEL, 16'hFFFF, '0, CHK_NONE, '0);
		add_row(ROW_PIXEL, 16'hFFFF, '0, CHK_GIVEN, RED_FULL);
		add_row(ROW_FLUSH, 16'hFFFF, '0, CHK_NONE, '0);
		add_row(ROW_PIXEL, 16'hFFFF, '0, CHK_GIVEN, GREEN_FULL);
		add_row(ROW_PIXEL, 16'hFFFF, '0, CHK_GIVEN, RED_FULL);
		add_row(ROW_PIXEL, 16'hFFFF, '0, CHK_GIVEN, GREEN_FULL);
		add_row(ROW_PIXEL, 16'hFFFF, '0, CHK_GIVEN, WHITE_FULL);
		add_row(ROW_FLUSH, 16'h0000, '0, CHK_GIVEN, GREEN_FULL);
		add_row(ROW_FLUSH, 16'h0000, '0, CHK_GIVEN, RED_FULL);
		repeat (4) add_row(ROW_PIXEL, 16'h0000, '0, CHK_NONE, '0);
		repeat (5) add_row(ROW_PIXEL, 16'h0000, '0, CHK_GIVEN, BLACK);
		repeat (3) add_row(ROW_FLUSH, 16'hFFFF, '0, CHK_GIVEN, BLACK);
		add_row(ROW_FLUSH, 16'hFFFF, '0, CHK_GIVEN, BLACK_LAST);
		add_row(ROW_FLUSH, 16'h0000, '0, CHK_NONE, '0);

		foreach (stim_rows[i]) begin
			case (stim_rows[i].kind)
				ROW_SIZE: set_size(stim_rows[i].value[CFG_DATA_W-1:0], stim_rows[i].height);
				ROW_PIXEL: send_word(CMD_PIXEL, stim_rows[i].value, stim_rows[i].check,
					stim_rows[i].given);
				default: send_word(CMD_FLUSH, stim_rows[i].value, stim_rows[i].check,
					stim_rows[i].given);
			endcase
		end

		while (stim_count < 1250) begin
			if ($urandom_range(2, 0) == 0)
				pick_small_size();
			gap_pct = pick_rate();
			stall_pct = pick_rate();
			run_frame($urandom_range(7, 0) == 0);
		end

		// The widest and the tallest frame, both from out-of-range values.
		gap_pct = 2;
		stall_pct = 2;
		set_size(13'h1FFF, 13'd2);
		run_frame(1'b0);
		set_size(13'd0, 13'h1FFF);
		run_frame(1'b0);

		gap_pct = 0;
		stall_pct = 0;
		tail_mark = stim_count;
		while (stim_count < tail_mark + 200) begin
			if ($urandom_range(2, 0) == 0)
				pick_small_size();
			run_frame(1'b0);
		end

		wait_drained();
		if (expected_q.size() != 0) begin
			errors += expected_q.size();
			$display("%0d RGB words never arrived", expected_q.size());
		end
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
